### hw/rtl/kslp_pkg.sv
package kslp_pkg;

    localparam int COUNT_WIDTH  = 16;
    localparam int THRESH_WIDTH = 16;
    localparam int CMP_WIDTH    = (COUNT_WIDTH > THRESH_WIDTH) ? COUNT_WIDTH : THRESH_WIDTH;
    localparam int ROW_WIDTH    = 4;
    localparam int COL_WIDTH    = 4;
    localparam int COL_IDX_W    = 2;
    localparam int KEY_WIDTH    = 5;

    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(500);
    localparam logic [COL_IDX_W-1:0]    LAST_COLUMN  = COL_IDX_W'(3);
    localparam logic [COL_WIDTH-1:0]    FIRST_COL_DRIVE = 4'b1110;
    localparam logic [KEY_WIDTH-1:0]    NO_KEY       = '0;
    localparam logic [KEY_WIDTH-1:0]    MAX_KEY      = KEY_WIDTH'(16);

    typedef struct packed {
        logic                 frame_end;
        logic [KEY_WIDTH-1:0] key;
    } scan_event_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key_number;
        logic                 long_press;
        logic                 press_done;
    } press_status_t;

endpackage

### hw/rtl/kslp_scan.sv
module kslp_scan
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic [kslp_pkg::ROW_WIDTH-1:0]      row_sense,
    output kslp_pkg::scan_event_t               scan_event,
    output logic [kslp_pkg::COL_WIDTH-1:0]      column_drive_next
);

    logic [kslp_pkg::COL_IDX_W-1:0] column_index_reg;
    logic [kslp_pkg::COL_IDX_W-1:0] column_index_next;
    logic [11:0]                    scan_bits_reg;
    logic [11:0]                    scan_bits_next;
    logic [15:0]                    pressed;
    logic                           single_key;
    logic [3:0]                     key_pos;

    // inverted frame, first column in top nibble
    assign pressed    = ~{scan_bits_reg, row_sense};
    assign single_key = (pressed != 16'd0) && ((pressed & (pressed - 16'd1)) == 16'd0);

    always_comb
    begin
        key_pos = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (pressed[i])
            begin
                key_pos = key_pos | 4'(i);
            end
        end
    end

    always_comb
    begin
        scan_event.frame_end = (column_index_reg == kslp_pkg::LAST_COLUMN);
        scan_event.key       = single_key ? (kslp_pkg::MAX_KEY - {1'b0, key_pos})
                                          : kslp_pkg::NO_KEY;
        if (scan_event.frame_end)
        begin
            column_index_next = '0;
            scan_bits_next    = '1;
        end
        else
        begin
            column_index_next = column_index_reg + kslp_pkg::COL_IDX_W'(1);
            scan_bits_next    = {scan_bits_reg[7:0], row_sense};
        end
        column_drive_next = ~(kslp_pkg::COL_WIDTH'(1) << column_index_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_index_reg <= '0;
            scan_bits_reg    <= '1;
        end
        else if (step)
        begin
            column_index_reg <= column_index_next;
            scan_bits_reg    <= scan_bits_next;
        end
    end

endmodule

### hw/rtl/kslp_press.sv
module kslp_press
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  step,
    input  kslp_pkg::scan_event_t                 scan_event,
    input  logic [kslp_pkg::THRESH_WIDTH-1:0]     long_threshold,
    output kslp_pkg::press_status_t               status_next
);

    logic [kslp_pkg::KEY_WIDTH-1:0]   latched_key_reg;
    logic [kslp_pkg::KEY_WIDTH-1:0]   latched_key_next;
    logic [kslp_pkg::COUNT_WIDTH-1:0] press_count_reg;
    logic [kslp_pkg::COUNT_WIDTH-1:0] press_count_next;
    logic                             key_held_reg;
    logic                             key_held_next;
    logic                             long_flag_reg;
    logic                             long_flag_next;
    logic                             done;
    logic [kslp_pkg::CMP_WIDTH-1:0]   count_ext;
    logic [kslp_pkg::CMP_WIDTH-1:0]   thresh_ext;

    assign count_ext  = kslp_pkg::CMP_WIDTH'(press_count_reg);
    assign thresh_ext = kslp_pkg::CMP_WIDTH'(long_threshold);

    always_comb
    begin
        latched_key_next = latched_key_reg;
        press_count_next = press_count_reg;
        key_held_next    = key_held_reg;
        long_flag_next   = long_flag_reg;
        done             = 1'b0;
        if (scan_event.frame_end)
        begin
            if (scan_event.key != kslp_pkg::NO_KEY)
            begin
                if (!key_held_reg)
                begin
                    latched_key_next = scan_event.key;
                    key_held_next    = 1'b1;
                end
                // saturating count
                if (press_count_reg != '1)
                begin
                    press_count_next = press_count_reg + kslp_pkg::COUNT_WIDTH'(1);
                end
            end
            else if (key_held_reg)
            begin
                if (count_ext < thresh_ext)
                begin
                    long_flag_next = 1'b0;
                end
                else if (count_ext > thresh_ext)
                begin
                    long_flag_next = 1'b1;
                end
                press_count_next = '0;
                key_held_next    = 1'b0;
                done             = 1'b1;
            end
        end
        status_next.key_number = latched_key_next;
        status_next.long_press = long_flag_next;
        status_next.press_done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_key_reg <= '0;
            press_count_reg <= '0;
            key_held_reg    <= 1'b0;
            long_flag_reg   <= 1'b0;
        end
        else if (step)
        begin
            latched_key_reg <= latched_key_next;
            press_count_reg <= press_count_next;
            key_held_reg    <= key_held_next;
            long_flag_reg   <= long_flag_next;
        end
    end

endmodule

### hw/rtl/keypad_scan_long_press_unit.sv
// keypad_scan_long_press_unit: 4x4 key matrix scanner with short/long press
// classification.
// input channel (in_valid/in_ready, row_sense): one transfer per row sample,
//   active-low rows for the column currently driven.
// result channel (out_valid/out_ready): one transfer per input transfer with
//   column_drive (column to sample next), key_number, long_press, press_done.
// config channel (cfg_valid/cfg_ready, cfg_data): writes long_threshold in
//   scan frames; cfg_ready is always high, write only while idle.
// path: an input transfer is held in the input register, then its result is
//   captured in the result register when that register is free or being taken.
// throughput: one item per cycle; in_ready drops only while the input register
//   is full and the result register holds a result the receiver has not taken.
// stall: with out_ready low, the pending result holds and one more item waits
//   in the input register; no scan or press state moves until the result leaves.
// reset: first column selected, no key latched, press counter cleared,
//   long_press low, threshold back to 500 frames.
module keypad_scan_long_press_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [kslp_pkg::ROW_WIDTH-1:0]        row_sense,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [kslp_pkg::COL_WIDTH-1:0]        column_drive,
    output logic [kslp_pkg::KEY_WIDTH-1:0]        key_number,
    output logic                                  long_press,
    output logic                                  press_done,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [kslp_pkg::THRESH_WIDTH-1:0]     cfg_data
);

    logic                                 in_valid_reg;
    logic [kslp_pkg::ROW_WIDTH-1:0]       row_reg;
    logic                                 out_valid_reg;
    logic [kslp_pkg::COL_WIDTH-1:0]       column_drive_reg;
    kslp_pkg::press_status_t              status_reg;
    logic [kslp_pkg::THRESH_WIDTH-1:0]    long_threshold_reg;
    logic                                 advance;
    kslp_pkg::scan_event_t                scan_event;
    logic [kslp_pkg::COL_WIDTH-1:0]       column_drive_next;
    kslp_pkg::press_status_t              status_next;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    kslp_scan u_scan
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (advance),
        .row_sense         (row_reg),
        .scan_event        (scan_event),
        .column_drive_next (column_drive_next)
    );

    kslp_press u_press
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .scan_event     (scan_event),
        .long_threshold (long_threshold_reg),
        .status_next    (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            long_threshold_reg <= kslp_pkg::THRESH_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                long_threshold_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            row_reg <= row_sense;
        end
        if (advance)
        begin
            column_drive_reg <= column_drive_next;
            status_reg       <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign column_drive = column_drive_reg;
    assign key_number   = status_reg.key_number;
    assign long_press   = status_reg.long_press;
    assign press_done   = status_reg.press_done;

`ifndef SYNTHESIS
    a_done_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && press_done |-> column_drive == kslp_pkg::FIRST_COL_DRIVE)
        else $error("press_done outside a frame end");

    a_one_column: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(~column_drive))
        else $error("column_drive does not select exactly one column");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_number <= kslp_pkg::MAX_KEY)
        else $error("key_number out of range");

    a_no_step_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !advance)
        else $error("pipeline advanced over a held result");
`endif

endmodule
